// ----- rtl/lbq_pkg.sv -----
// ----------------------------------------------------------------------------
// lbq_pkg
// Shared constants and types for the linear byte queue with search.
// ----------------------------------------------------------------------------
`default_nettype none

package lbq_pkg;

  localparam int BUFFER_BYTES    = 256;
  localparam int MAX_BURST_BYTES = 8;
  localparam int ADDR_W          = $clog2(BUFFER_BYTES);
  localparam int IDX_W           = ADDR_W + 1;
  localparam int K_W             = 3;

  // Item kinds
  localparam logic [2:0] KIND_WR_BYTE  = 3'd0;
  localparam logic [2:0] KIND_WR_BURST = 3'd1;
  localparam logic [2:0] KIND_PEEK     = 3'd2;
  localparam logic [2:0] KIND_POP      = 3'd3;
  localparam logic [2:0] KIND_POP_N    = 3'd4;
  localparam logic [2:0] KIND_SRCH_B   = 3'd5;
  localparam logic [2:0] KIND_SRCH_P   = 3'd6;
  localparam logic [2:0] KIND_RESET    = 3'd7;

  // Classified command passed from front to back
  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] payload;
    logic [8:0]  amount;
    logic [8:0]  start_offset;
    logic        burst_ok;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/linear_byte_queue_with_search_core.sv -----
// ----------------------------------------------------------------------------
// linear_byte_queue_with_search_core
// Non-circular byte queue with byte and pattern search.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (kind, payload, amount, start_offset) enter on in_valid while
//   in_stall is low; each produces exactly one result beat (ok, head_byte,
//   position, fill_level) on out_valid, taken when out_stall is low.
//   A two-entry command queue sits in front of the execution engine, so up
//   to two beats can be taken while the engine works or the result waits.
//   Write byte and reset execute at once, then give the result; peek,
//   pop and pop n first read the head from the byte store, then give the
//   result; a burst write stores its bytes one by one on the write port.
//   Byte search reads and then compares each scanned byte, pattern search
//   each compared byte; both are bound by the single registered read port.
//   The capacity register is written on cfg_valid (cfg_ready is always high)
//   and must only be written while the block is idle.
//   Reset (rst_n low, synchronous) empties both queues, zeroes the indices
//   and sets capacity to 256; store contents are undefined until written.
//   While out_stall is high the result beat holds and the engine waits.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_byte_queue_with_search_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_kind,
  input  wire logic [63:0] in_payload,
  input  wire logic [8:0]  in_amount,
  input  wire logic [8:0]  in_start_offset,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_ok,
  output logic [7:0]       out_head_byte,
  output logic [8:0]       out_position,
  output logic [8:0]       out_fill_level,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_capacity
);
  import lbq_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  lbq_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_payload      (in_payload),
    .in_amount       (in_amount),
    .in_start_offset (in_start_offset),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  lbq_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_data       (cfg_capacity),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ok         (out_ok),
    .out_head_byte  (out_head_byte),
    .out_position   (out_position),
    .out_fill_level (out_fill_level)
  );

endmodule

`default_nettype wire

// ----- rtl/lbq_front.sv -----
// ----------------------------------------------------------------------------
// lbq_front
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lbq_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [2:0]    in_kind,
  input  wire logic [63:0]   in_payload,
  input  wire logic [8:0]    in_amount,
  input  wire logic [8:0]    in_start_offset,
  output logic               cmd_valid,
  output lbq_pkg::cmd_t      cmd,
  input  wire logic          cmd_pop
);
  import lbq_pkg::*;

  cmd_t       q_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       new_cmd;

  // Classify the incoming beat
  always_comb begin
    new_cmd.kind         = in_kind;
    new_cmd.payload      = in_payload;
    new_cmd.amount       = in_amount;
    new_cmd.start_offset = in_start_offset;
    new_cmd.burst_ok     = (in_amount != 9'd0) &&
                           (in_amount <= 9'(MAX_BURST_BYTES));
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rptr_r];

  // Advance pointers and count
  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = cmd_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store the beat
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= new_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lbq_engine.sv -----
// ----------------------------------------------------------------------------
// lbq_engine
// Executes queued commands against the byte store and drives the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module lbq_engine (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire lbq_pkg::cmd_t cmd,
  output logic               cmd_pop,
  input  wire logic          cfg_valid,
  input  wire logic [8:0]    cfg_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               out_ok,
  output logic [7:0]         out_head_byte,
  output logic [8:0]         out_position,
  output logic [8:0]         out_fill_level
);
  import lbq_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_HEADW  = 4'd1;
  localparam logic [3:0] ST_WB     = 4'd2;
  localparam logic [3:0] ST_SB_RD  = 4'd3;
  localparam logic [3:0] ST_SB_CMP = 4'd4;
  localparam logic [3:0] ST_PS_RD  = 4'd5;
  localparam logic [3:0] ST_PS_CMP = 4'd6;
  localparam logic [3:0] ST_DONE   = 4'd7;

  logic [7:0]       mem [BUFFER_BYTES];
  logic [7:0]       rdata_r;
  logic [ADDR_W-1:0] raddr, waddr;
  logic             we;
  logic [7:0]       wdata;

  logic [3:0]       st_r, st_nxt;
  cmd_t             c_r, c_nxt;
  logic [IDX_W-1:0] rd_r, rd_nxt, wr_r, wr_nxt, i_r, i_nxt, pos_r, pos_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic             ok_r, ok_nxt;
  logic [7:0]       head_r, head_nxt;
  logic [8:0]       cap_r;
  logic [IDX_W-1:0] cap_eff;
  logic [IDX_W:0]   end_sum;
  logic [7:0]       pbyte;
  logic             k_last;
  logic [IDX_W-1:0] wr0;
  logic [IDX_W-1:0] raised;

  logic             ov_r;
  logic             o_ok_r;
  logic [7:0]       o_head_r;
  logic [8:0]       o_pos_r, o_fill_r;
  logic             load_out;

  // Clamp capacity to between 1 and the store size
  always_comb begin
    if (cap_r == 9'd0) begin
      cap_eff = IDX_W'(1);
    end else if ({1'b0, cap_r} > 10'(BUFFER_BYTES)) begin
      cap_eff = IDX_W'(BUFFER_BYTES);
    end else begin
      cap_eff = IDX_W'(cap_r);
    end
  end

  assign pbyte  = c_r.payload[{k_r, 3'b000} +: 8];
  assign k_last = ({1'b0, k_r} == (c_r.amount[3:0] - 4'd1));
  assign wr0    = (wr_r == rd_r) ? '0 : wr_r;
  assign raised = (cmd.start_offset > rd_r) ? cmd.start_offset : rd_r;
  assign load_out = (st_r == ST_DONE) && (!ov_r || !out_stall);

  // Sequencer
  always_comb begin
    st_nxt   = st_r;
    c_nxt    = c_r;
    rd_nxt   = rd_r;
    wr_nxt   = wr_r;
    i_nxt    = i_r;
    k_nxt    = k_r;
    ok_nxt   = ok_r;
    pos_nxt  = pos_r;
    head_nxt = head_r;
    cmd_pop  = 1'b0;
    raddr    = rd_r[ADDR_W-1:0];
    waddr    = wr_r[ADDR_W-1:0];
    wdata    = pbyte;
    we       = 1'b0;
    end_sum  = {1'b0, i_r} + {1'b0, c_r.amount};
    unique case (st_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          c_nxt    = cmd;
          ok_nxt   = 1'b0;
          pos_nxt  = '0;
          head_nxt = 8'd0;
          k_nxt    = '0;
          i_nxt    = raised;
          st_nxt   = ST_DONE;
          unique case (cmd.kind)
            KIND_WR_BYTE: begin
              rd_nxt = (wr_r == rd_r) ? '0 : rd_r;
              wr_nxt = wr0;
              if (wr0 < cap_eff) begin
                we     = 1'b1;
                waddr  = wr0[ADDR_W-1:0];
                wdata  = cmd.payload[7:0];
                wr_nxt = wr0 + IDX_W'(1);
                ok_nxt = 1'b1;
              end
            end
            KIND_WR_BURST: begin
              if (cmd.burst_ok) begin
                rd_nxt = (wr_r == rd_r) ? '0 : rd_r;
                wr_nxt = wr0;
                if (({1'b0, wr0} + {1'b0, cmd.amount}) <= {1'b0, cap_eff}) begin
                  st_nxt = ST_WB;
                end
              end
            end
            KIND_RESET: begin
              rd_nxt = '0;
              wr_nxt = '0;
              ok_nxt = 1'b1;
            end
            default: begin
              st_nxt = ST_HEADW;
            end
          endcase
        end
      end
      ST_HEADW: begin
        head_nxt = (rd_r < wr_r) ? rdata_r : 8'd0;
        pos_nxt  = '0;
        st_nxt   = ST_DONE;
        unique case (c_r.kind)
          KIND_PEEK: ok_nxt = (rd_r != wr_r);
          KIND_POP: begin
            if (rd_r != wr_r) begin
              rd_nxt = rd_r + IDX_W'(1);
              ok_nxt = 1'b1;
            end
          end
          KIND_POP_N: begin
            if ((wr_r - rd_r) >= c_r.amount) begin
              rd_nxt = rd_r + c_r.amount;
              ok_nxt = 1'b1;
            end
          end
          KIND_SRCH_B: begin
            pos_nxt = i_r;
            st_nxt  = ST_SB_RD;
          end
          KIND_SRCH_P: begin
            pos_nxt = i_r;
            st_nxt  = ST_PS_RD;
          end
          default: st_nxt = ST_DONE;
        endcase
      end
      ST_WB: begin
        we    = 1'b1;
        waddr = ADDR_W'(wr_r + IDX_W'(k_r));
        if (k_last) begin
          wr_nxt = wr_r + c_r.amount;
          ok_nxt = 1'b1;
          st_nxt = ST_DONE;
        end else begin
          k_nxt = k_r + K_W'(1);
        end
      end
      ST_SB_RD: begin
        raddr = i_r[ADDR_W-1:0];
        if (i_r < wr_r) begin
          st_nxt = ST_SB_CMP;
        end else begin
          pos_nxt = i_r;
          st_nxt  = ST_DONE;
        end
      end
      ST_SB_CMP: begin
        if (rdata_r == c_r.payload[7:0]) begin
          ok_nxt  = 1'b1;
          pos_nxt = i_r;
          st_nxt  = ST_DONE;
        end else begin
          i_nxt  = i_r + IDX_W'(1);
          st_nxt = ST_SB_RD;
        end
      end
      ST_PS_RD: begin
        raddr = ADDR_W'(i_r + IDX_W'(k_r));
        if (c_r.burst_ok && (end_sum <= {1'b0, wr_r})) begin
          st_nxt = ST_PS_CMP;
        end else begin
          st_nxt = ST_DONE;
        end
      end
      ST_PS_CMP: begin
        if (rdata_r != pbyte) begin
          i_nxt  = i_r + IDX_W'(1);
          k_nxt  = '0;
          st_nxt = ST_PS_RD;
        end else if (k_last) begin
          ok_nxt  = 1'b1;
          pos_nxt = end_sum[IDX_W-1:0];
          st_nxt  = ST_DONE;
        end else begin
          k_nxt  = k_r + K_W'(1);
          st_nxt = ST_PS_RD;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      rd_r  <= '0;
      wr_r  <= '0;
      cap_r <= 9'(BUFFER_BYTES);
      ov_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (load_out) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    c_r    <= c_nxt;
    i_r    <= i_nxt;
    k_r    <= k_nxt;
    ok_r   <= ok_nxt;
    pos_r  <= pos_nxt;
    head_r <= head_nxt;
    if (load_out) begin
      o_ok_r   <= ok_r;
      o_head_r <= head_r;
      o_pos_r  <= pos_r;
      o_fill_r <= wr_r - rd_r;
    end
  end

  // Byte store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign out_valid      = ov_r;
  assign out_ok         = o_ok_r;
  assign out_head_byte  = o_head_r;
  assign out_position   = o_pos_r;
  assign out_fill_level = o_fill_r;

  // Checks
  a_rd_le_wr: assert property (@(posedge clk) disable iff (!rst_n) rd_r <= wr_r)
    else $error("read index passed write index");
  a_wr_le_buf: assert property (@(posedge clk) disable iff (!rst_n)
    wr_r <= IDX_W'(BUFFER_BYTES))
    else $error("write index beyond store");
  a_wb_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WB) |-> ((wr_r + IDX_W'(k_r)) < cap_eff))
    else $error("burst write beyond capacity");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (st_r == ST_IDLE) ##1 (st_r != ST_IDLE))
    else $error("command taken outside idle");

endmodule

`default_nettype wire

// ----- dv/lbq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbq_checker
// Watches the input, result and capacity channels of the byte queue, keeps
// its own image of the store, indices and capacity, and compares every
// result beat field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module lbq_checker
  import lbq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [63:0] in_payload,
  input  logic [8:0]  in_amount,
  input  logic [8:0]  in_start_offset,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_ok,
  input  logic [7:0]  out_head_byte,
  input  logic [8:0]  out_position,
  input  logic [8:0]  out_fill_level,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [8:0]  cfg_capacity,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic       ok;
    logic [7:0] head_byte;
    logic [8:0] position;
    logic [8:0] fill_level;
  } queue_result_t;

  logic [7:0]    store_img [BUFFER_BYTES];
  int            rd_idx;
  int            wr_idx;
  logic [8:0]    cap_reg;
  queue_result_t result_fifo[$];

  assign pending = result_fifo.size();

  // Compute the result of one item and advance the image state
  task automatic queue_step(input logic [2:0] kind, input logic [63:0] pl,
                            input logic [8:0] amt, input logic [8:0] st,
                            output queue_result_t r);
    int cap_e;
    int i;
    int k;
    bit hit;
    bit burst_len_ok;
    r = '0;
    cap_e = (cap_reg == 0) ? 1 : ((cap_reg > BUFFER_BYTES) ? BUFFER_BYTES : int'(cap_reg));
    burst_len_ok = (amt >= 1) && (amt <= MAX_BURST_BYTES);
    if (kind inside {KIND_PEEK, KIND_POP, KIND_POP_N, KIND_SRCH_B, KIND_SRCH_P})
      r.head_byte = (rd_idx < wr_idx) ? store_img[rd_idx] : 8'd0;
    case (kind)
      KIND_WR_BYTE: begin
        if (wr_idx == rd_idx) begin
          rd_idx = 0;
          wr_idx = 0;
        end
        if (wr_idx < cap_e) begin
          store_img[wr_idx] = pl[7:0];
          wr_idx++;
          r.ok = 1'b1;
        end
      end
      KIND_WR_BURST: begin
        if (burst_len_ok) begin
          if (wr_idx == rd_idx) begin
            rd_idx = 0;
            wr_idx = 0;
          end
          if (wr_idx + amt <= cap_e) begin
            for (k = 0; k < amt; k++) store_img[wr_idx + k] = pl[8*k +: 8];
            wr_idx += amt;
            r.ok = 1'b1;
          end
        end
      end
      KIND_PEEK: r.ok = (rd_idx != wr_idx);
      KIND_POP: begin
        if (rd_idx != wr_idx) begin
          rd_idx++;
          r.ok = 1'b1;
        end
      end
      KIND_POP_N: begin
        if (wr_idx - rd_idx >= amt) begin
          rd_idx += amt;
          r.ok = 1'b1;
        end
      end
      KIND_SRCH_B: begin
        i = (st > rd_idx) ? int'(st) : rd_idx;
        while (i < wr_idx && store_img[i] != pl[7:0]) i++;
        r.ok = (i < wr_idx);
        r.position = i[8:0];
      end
      KIND_SRCH_P: begin
        i = (st > rd_idx) ? int'(st) : rd_idx;
        r.position = i[8:0];
        if (burst_len_ok) begin
          for (; i + amt <= wr_idx && !r.ok; i++) begin
            hit = 1'b1;
            for (k = 0; k < amt; k++)
              if (store_img[i + k] != pl[8*k +: 8]) hit = 1'b0;
            if (hit) begin
              r.ok = 1'b1;
              r.position = 9'(i + amt);
            end
          end
        end
      end
      default: begin
        rd_idx = 0;
        wr_idx = 0;
        r.ok = 1'b1;
      end
    endcase
    r.fill_level = 9'(wr_idx - rd_idx);
  endtask

  // Predict on input beats, compare on result beats, track capacity writes
  always @(posedge clk) begin
    queue_result_t pred;
    queue_result_t want;
    if (!rst_n) begin
      rd_idx = 0;
      wr_idx = 0;
      cap_reg = 9'd256;
      result_fifo.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) cap_reg = cfg_capacity;
      if (in_valid && !in_stall) begin
        queue_step(in_kind, in_payload, in_amount, in_start_offset, pred);
        result_fifo.push_back(pred);
      end
      if (out_valid && !out_stall) begin
        if (result_fifo.size() == 0) begin
          $error("result beat with no prediction waiting");
          fail_count++;
        end else begin
          want = result_fifo.pop_front();
          if (out_ok !== want.ok) begin
            $error("ok: expected %0d, actual %0d", want.ok, out_ok);
            fail_count++;
          end
          if (out_head_byte !== want.head_byte) begin
            $error("head_byte: expected %0d, actual %0d", want.head_byte, out_head_byte);
            fail_count++;
          end
          if (out_position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, out_position);
            fail_count++;
          end
          if (out_fill_level !== want.fill_level) begin
            $error("fill_level: expected %0d, actual %0d", want.fill_level, out_fill_level);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ----- dv/tb_linear_byte_queue_with_search_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_byte_queue_with_search_core
// Drives directed and random item beats and capacity writes into the byte
// queue with random gaps and result stalls; the checker judges the results.
// ----------------------------------------------------------------------------
module tb_linear_byte_queue_with_search_core;
  import lbq_pkg::*;

  localparam int CYCLE_LIMIT = 12000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind = KIND_PEEK;
  logic [63:0] in_payload = '0;
  logic [8:0]  in_amount = '0;
  logic [8:0]  in_start_offset = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_ok;
  logic [7:0]  out_head_byte;
  logic [8:0]  out_position;
  logic [8:0]  out_fill_level;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_capacity = 9'd256;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  bit          busy_mode = 1'b0;  // no gaps and no stalls while set
  int          stall_left = 0;
  int          fill_est = 0;

  always #6 clk = ~clk;

  linear_byte_queue_with_search_core dut (.*);

  lbq_checker u_checker (.*);

  // End a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** linear_byte_queue_with_search_core: FAILED **");
      $finish;
    end
  end

  // Draw a stall length for each result beat
  always @(posedge clk) begin
    int n;
    n = stall_left;
    if (out_valid && !out_stall) n = busy_mode ? 0 : $urandom_range(0, 12);
    if (n > 0) begin
      out_stall <= 1'b1;
      n--;
    end else begin
      out_stall <= 1'b0;
    end
    stall_left = n;
  end

  // Send one item beat after a random gap and hold it until taken
  task automatic send_item(input logic [2:0] kind, input logic [63:0] pl,
                           input logic [8:0] amt, input logic [8:0] st);
    int gap;
    gap = busy_mode ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_payload <= pl;
    in_amount <= amt;
    in_start_offset <= st;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    // rough fill tracking to steer random pops
    case (kind)
      KIND_WR_BYTE: fill_est++;
      KIND_WR_BURST: if (amt >= 1 && amt <= 8) fill_est += amt;
      KIND_POP: if (fill_est > 0) fill_est--;
      KIND_RESET: fill_est = 0;
      default: ;
    endcase
  endtask

  // Hold until every result is back and the engine is quiet
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [8:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_capacity <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Payload of bytes from a tiny alphabet so searches find matches
  function automatic logic [63:0] narrow_bytes();
    logic [63:0] v;
    for (int k = 0; k < 8; k++) v[8*k +: 8] = 8'($urandom_range(0, 2));
    return v;
  endfunction

  task automatic random_item();
    int sel;
    logic [2:0]  kind;
    logic [63:0] pl;
    logic [8:0]  amt;
    logic [8:0]  st;
    sel = $urandom_range(0, 99);
    pl = ($urandom_range(0, 2) == 0) ? rand64() : narrow_bytes();
    amt = 9'($urandom_range(1, 8));
    st = 9'($urandom_range(0, 40));
    if ($urandom_range(0, 15) == 0) amt = 9'($urandom());
    if ($urandom_range(0, 10) == 0) st = 9'($urandom());
    if (sel < 22) kind = KIND_WR_BYTE;
    else if (sel < 44) kind = KIND_WR_BURST;
    else if (sel < 50) kind = KIND_PEEK;
    else if (sel < 60) kind = KIND_POP;
    else if (sel < 68) begin
      kind = KIND_POP_N;
      if ($urandom_range(0, 3) != 0) amt = 9'($urandom_range(0, fill_est > 0 ? fill_est : 1));
    end
    else if (sel < 82) kind = KIND_SRCH_B;
    else if (sel < 97) begin
      kind = KIND_SRCH_P;
      if ($urandom_range(0, 1) == 0) amt = 9'($urandom_range(1, 3));
    end
    else kind = KIND_RESET;
    send_item(kind, pl, amt, st);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty cases, length extremes, exact fill, searches
    send_item(KIND_PEEK, '0, 9'd0, 9'd0);
    send_item(KIND_POP, '0, 9'd0, 9'd0);
    send_item(KIND_POP_N, '0, 9'd0, 9'd0);
    send_item(KIND_POP_N, '0, 9'd1, 9'd0);
    send_item(KIND_SRCH_B, '0, 9'd0, 9'd0);
    send_item(KIND_WR_BYTE, 64'hFFFF_FFFF_FFFF_FFFF, 9'd0, 9'd0);
    send_item(KIND_WR_BURST, 64'h0807_0605_0403_0201, 9'd8, 9'd0);
    send_item(KIND_WR_BURST, 64'h1111, 9'd0, 9'd0);
    send_item(KIND_WR_BURST, 64'h2222, 9'd9, 9'd0);
    send_item(KIND_WR_BURST, 64'h3333, 9'd511, 9'd0);
    send_item(KIND_PEEK, '0, 9'd0, 9'd0);
    send_item(KIND_SRCH_B, 64'h05, 9'd0, 9'd0);
    send_item(KIND_SRCH_B, 64'hEE, 9'd0, 9'd3);
    send_item(KIND_SRCH_B, 64'h01, 9'd0, 9'd511);
    send_item(KIND_SRCH_P, 64'h0504_03, 9'd3, 9'd0);
    send_item(KIND_SRCH_P, 64'h0807_0605_0403_0201, 9'd8, 9'd0);
    send_item(KIND_SRCH_P, 64'h03, 9'd0, 9'd2);
    send_item(KIND_SRCH_P, 64'h03, 9'd9, 9'd300);
    send_item(KIND_POP, '0, 9'd0, 9'd0);
    send_item(KIND_POP_N, '0, 9'd100, 9'd0);
    send_item(KIND_POP_N, '0, 9'd8, 9'd0);
    send_item(KIND_WR_BYTE, 64'h5A, 9'd0, 9'd0);
    send_item(KIND_RESET, '0, 9'd0, 9'd0);

    // Exact fill at capacity 3, then capacity lowered below write index
    write_capacity(9'd3);
    send_item(KIND_WR_BURST, 64'hAABBCC, 9'd3, 9'd0);
    send_item(KIND_WR_BYTE, 64'h01, 9'd0, 9'd0);
    write_capacity(9'd0);
    send_item(KIND_WR_BYTE, 64'h02, 9'd0, 9'd0);
    send_item(KIND_POP_N, '0, 9'd3, 9'd0);
    send_item(KIND_WR_BYTE, 64'h03, 9'd0, 9'd0);
    send_item(KIND_WR_BYTE, 64'h04, 9'd0, 9'd0);
    write_capacity(9'd511);
    fill_est = 1;

    // Random phases over several capacities
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_capacity(9'd256);
        1: write_capacity(9'd1);
        2: write_capacity(9'($urandom_range(2, 40)));
        3: write_capacity(9'd300);
        4: write_capacity(9'd16);
        default: write_capacity(9'($urandom()));
      endcase
      busy_mode = (phase == 3);
      for (int n = 0; n < 90; n++) begin
        random_item();
        if (phase == 2 && n == 45) drain();
      end
      busy_mode = 1'b0;
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("** linear_byte_queue_with_search_core: PASSED **");
    end else begin
      $display("** linear_byte_queue_with_search_core: FAILED **");
    end
    $finish;
  end

endmodule
